// ----- sv/bgd_pkg.sv -----
// package for the button gesture detector
// request and result structs, register indexes, reset values and state type
// no dependencies
package bgd_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd2;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd50;
  localparam logic [15:0] CLICK_RESET = 16'd400;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PRESSED = 2'd1,
    ST_RELEASED = 2'd2,
    ST_SECOND = 2'd3
  } gesture_state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic level_pressed;
  } bgd_in_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic long_start_event;
    logic long_end_event;
    logic click_event;
    logic double_click_event;
    logic is_pressed;
    logic is_long_pressed;
  } bgd_out_t;

endpackage

// ----- sv/button_gesture_detector.sv -----
// Button gesture detector: one poll per request, one result per poll. A request is
// taken every cycle while results are taken; each result passes through the request
// register and the result register, and the state machine advances once per poll with a
// subtract and compare on the stored stamps.
// While a result waits at the output the request register can still take one request.
// Configuration writes are taken every cycle; index 3 is ignored.
// depends on bgd_pkg
module button_gesture_detector #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bgd_pkg::bgd_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output bgd_pkg::bgd_out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bgd_pkg::*;

  logic [7:0] debounce_ms;
  logic [15:0] click_ms;
  logic [15:0] long_press_ms;

  logic req_valid;
  bgd_in_t req;
  logic advance;
  logic step;

  gesture_state_t state, state_next;
  logic long_flag, long_flag_next;
  logic press_reported, press_reported_next;
  logic [TIME_BITS-1:0] press_stamp, press_stamp_next;
  logic [TIME_BITS-1:0] release_stamp, release_stamp_next;

  logic [63:0] now_wide;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] since_rel;
  logic [TIME_BITS-1:0] dbnc_t;
  logic [TIME_BITS-1:0] click_t;
  logic [TIME_BITS-1:0] long_t;
  bgd_out_t result;

  assign cfg_ready = 1'b1;
  assign advance = !out_valid || out_ready;
  assign step = req_valid && advance;
  assign in_ready = !req_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      click_ms <= CLICK_RESET;
      long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ms <= cfg_data[7:0];
        REG_CLICK: click_ms <= cfg_data;
        REG_LONG_PRESS: long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  // elapsed times modulo 2^TIME_BITS
  assign now_wide = {32'd0, req.now_ms};
  assign now = now_wide[TIME_BITS-1:0];
  assign held = now - press_stamp;
  assign since_rel = now - release_stamp;
  assign dbnc_t = {{(TIME_BITS-8){1'b0}}, debounce_ms};
  assign click_t = {{(TIME_BITS-16){1'b0}}, click_ms};
  assign long_t = {{(TIME_BITS-16){1'b0}}, long_press_ms};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.level_pressed) state_next = ST_PRESSED;
      end
      ST_PRESSED: begin
        if (!req.level_pressed) begin
          state_next = (held <= dbnc_t) ? ST_IDLE : ST_RELEASED;
        end
      end
      ST_RELEASED: begin
        if (req.level_pressed && since_rel > dbnc_t) begin
          state_next = ST_SECOND;
        end else if (held > long_t || held > click_t) begin
          state_next = ST_IDLE;
        end
      end
      ST_SECOND: begin
        if (!req.level_pressed && held > dbnc_t) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result = '0;
    long_flag_next = long_flag;
    press_reported_next = press_reported;
    press_stamp_next = press_stamp;
    release_stamp_next = release_stamp;
    case (state)
      ST_IDLE: begin
        if (req.level_pressed) press_stamp_next = now;
      end
      ST_PRESSED: begin
        if (req.level_pressed) begin
          if (held > dbnc_t && !press_reported) begin
            press_reported_next = 1'b1;
            result.press_event = 1'b1;
          end
          if (held > long_t && !long_flag) begin
            long_flag_next = 1'b1;
            result.long_start_event = 1'b1;
          end
        end else begin
          if (held > dbnc_t) begin
            press_reported_next = 1'b0;
            result.release_event = 1'b1;
          end
          release_stamp_next = now;
        end
      end
      ST_RELEASED: begin
        if (req.level_pressed && since_rel > dbnc_t) begin
          press_stamp_next = now;
        end else if (held > long_t) begin
          long_flag_next = 1'b0;
          result.long_end_event = 1'b1;
        end else if (held > click_t) begin
          result.click_event = 1'b1;
        end
      end
      ST_SECOND: begin
        if (!req.level_pressed && held > dbnc_t) result.double_click_event = 1'b1;
      end
      default: ;
    endcase
    result.is_pressed = (state_next == ST_PRESSED);
    result.is_long_pressed = (state_next == ST_PRESSED) && long_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      long_flag <= 1'b0;
      press_reported <= 1'b0;
      press_stamp <= '0;
      release_stamp <= '0;
    end else if (step) begin
      state <= state_next;
      long_flag <= long_flag_next;
      press_reported <= press_reported_next;
      press_stamp <= press_stamp_next;
      release_stamp <= release_stamp_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_long_implies_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.is_long_pressed || out_data.is_pressed))
    else $error("long press status without pressed status");

  a_end_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({out_data.release_event, out_data.long_end_event,
                               out_data.click_event, out_data.double_click_event}) <= 1))
    else $error("more than one gesture end event in one result");

  a_hold_events_pressed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.press_event || out_data.long_start_event))
      |-> out_data.is_pressed)
    else $error("press or long start event outside pressed state");

  a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state) && $stable(press_stamp))
    else $error("gesture state moved without a step");
`endif

endmodule
